FILE: hw/rtl/bsm_pkg.sv
// Shared types, codes and constants of the bank switch mapper.
// No dependencies; bsm_xlat and the top level import this package.
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int ROM_ADDR_W         = 19;
  localparam int PRG_ADDR_WIDTH_DEF = 19;
  localparam int PRG_LG_W           = 3;

  localparam logic [PRG_LG_W-1:0] PRG_LG_RESET = 3'd5;
  localparam logic [PRG_LG_W-1:0] PRG_LG_MIN   = 3'd1;
  localparam logic [PRG_LG_W-1:0] PRG_LG_MAX   = 3'd6;

  // Bank register targets with special storage rules.
  localparam logic [2:0] BANK_R0 = 3'd0;
  localparam logic [2:0] BANK_R1 = 3'd1;
  localparam logic [2:0] BANK_R6 = 3'h6;
  localparam logic [2:0] BANK_R7 = 3'h7;

  localparam logic [7:0]  PRG_WIN_MASK = 8'h3F;
  localparam logic [12:0] CHR_A12      = 13'h1000;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_PRG   = 2'd1,
    MODE_CHR   = 2'd2,
    MODE_CLOCK = 2'd3
  } mode_t;

  // Register group chosen by address bits 14..13 of a write.
  typedef enum logic [1:0] {
    SEL_BANK   = 2'd0,
    SEL_MIRROR = 2'd1,
    SEL_IRQ_LR = 2'd2,
    SEL_IRQ_EN = 2'd3
  } reg_sel_t;

  typedef logic [7:0][7:0] bank_regs_t;

  // Mapping state that the translation logic reads.
  typedef struct packed {
    bank_regs_t          bank_regs;
    logic [7:0]          bank_ctrl;
    logic [PRG_LG_W-1:0] prg_lg;
  } xlat_ctl_t;

endpackage

FILE: hw/rtl/bsm_in_if.sv
// Input channel of the bank switch mapper: valid, ready and one item.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] addr;
  logic [7:0]  wdata;

  modport source (output valid, mode, addr, wdata, input ready);
  modport sink   (input valid, mode, addr, wdata, output ready);
endinterface

FILE: hw/rtl/bsm_out_if.sv
// Result channel of the bank switch mapper: valid, ready and one result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsm_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] rom_addr;
  logic        irq_pend;
  logic        mirror_code;

  modport source (output valid, rom_addr, irq_pend, mirror_code, input ready);
  modport sink   (input valid, rom_addr, irq_pend, mirror_code, output ready);
endinterface

FILE: hw/rtl/bsm_cfg_if.sv
// Configuration write channel of the bank switch mapper.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] size_lg;

  modport source (output valid, size_lg, input ready);
  modport sink   (input valid, size_lg, output ready);
endinterface

FILE: hw/rtl/bsm_xlat.sv
// Address translation for program and pattern reads of the mapper.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_xlat
  import bsm_pkg::*;
#(
  parameter int PRG_ADDR_WIDTH = PRG_ADDR_WIDTH_DEF
) (
  input  mode_t                 mode,
  input  logic [15:0]           addr,
  input  xlat_ctl_t             ctl,
  output logic [ROM_ADDR_W-1:0] rom_addr
);

  localparam int PW = (PRG_ADDR_WIDTH < ROM_ADDR_W) ? PRG_ADDR_WIDTH : ROM_ADDR_W;
  localparam logic [ROM_ADDR_W-1:0] PRG_MASK = {ROM_ADDR_W{1'b1}} >> (ROM_ADDR_W - PW);

  logic [PRG_LG_W-1:0]   lg;
  logic [6:0]            nbanks;
  logic [1:0]            win;
  logic [5:0]            win_bank;
  logic [ROM_ADDR_W-1:0] rom_mask;
  logic [ROM_ADDR_W-1:0] prg_addr;
  logic [12:0]           chr_e;
  logic [2:0]            chr_idx;
  logic [7:0]            pat_bank;
  logic [ROM_ADDR_W-1:0] chr_addr;

  always_comb begin
    // Out-of-range sizes saturate to the supported span.
    if (ctl.prg_lg < PRG_LG_MIN) begin
      lg = PRG_LG_MIN;
    end else if (ctl.prg_lg > PRG_LG_MAX) begin
      lg = PRG_LG_MAX;
    end else begin
      lg = ctl.prg_lg;
    end
    nbanks   = 7'd1 << lg;
    rom_mask = {ROM_ADDR_W{1'b1}} >> (PRG_LG_MAX - lg);

    // Program mode swaps the roles of windows 0 and 2.
    win = {addr[14] ^ (ctl.bank_ctrl[6] & ~addr[13]), addr[13]};
    unique case (win)
      2'd0:    win_bank = ctl.bank_regs[BANK_R6][5:0];
      2'd1:    win_bank = ctl.bank_regs[BANK_R7][5:0];
      2'd2:    win_bank = 6'(nbanks - 7'd2);
      default: win_bank = 6'(nbanks - 7'd1);
    endcase
    prg_addr = {win_bank, addr[12:0]} & rom_mask & PRG_MASK;

    // A12 inversion swaps the 2 KiB and 1 KiB halves of pattern space.
    chr_e = addr[12:0] ^ (ctl.bank_ctrl[7] ? CHR_A12 : 13'd0);
    if (chr_e[12]) begin
      chr_idx = {1'b0, chr_e[11:10]} + 3'd2;
    end else begin
      chr_idx = {2'b00, chr_e[11]};
    end
    pat_bank = ctl.bank_regs[chr_idx];
    if (chr_e[12]) begin
      chr_addr = {1'b0, pat_bank, chr_e[9:0]};
    end else begin
      chr_addr = {pat_bank, chr_e[10:0]};
    end

    unique case (mode)
      MODE_PRG: rom_addr = prg_addr;
      MODE_CHR: rom_addr = chr_addr;
      default:  rom_addr = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bank_switch_mapper_with_scanline_irq.sv
// Top level of the bank switch mapper with its scanline interrupt counter.
// Depends on bsm_pkg, the three channel interfaces and bsm_xlat.
`timescale 1ns / 1ps

//  Channel   Direction  Content
//  in_if     sink       mode, addr, wdata: one bus operation per item
//  out_if    source     rom_addr, irq_pend, mirror_code: one result per item
//  cfg_if    sink       size_lg: program ROM size, always ready
//
// One item is accepted per clock cycle while in_if.ready is high. The item
// waits in the input register, then the decode, the translation and the state
// update run in one pass into the result register, which it leaves when
// out_if.ready is high.
// Reset is synchronous and active low; it clears the mapper state, sets the
// program ROM size to 32 banks and empties both registers.
// A stalled result holds the result register; the input register still takes
// one more item, after which in_if.ready falls until the result is taken.

module bank_switch_mapper_with_scanline_irq
  import bsm_pkg::*;
#(
  parameter int PRG_ADDR_WIDTH = PRG_ADDR_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bsm_in_if.sink    in_if,
  bsm_out_if.source out_if,
  bsm_cfg_if.sink   cfg_if
);

  // Input register.
  logic        s1_valid_r;
  mode_t       s1_mode_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_wdata_r;

  // Result register.
  logic                  out_valid_r;
  logic [ROM_ADDR_W-1:0] out_rom_addr_r;
  logic                  out_irq_r;
  logic                  out_mirror_r;

  // Mapper state.
  logic [PRG_LG_W-1:0] prg_lg_r;
  bank_regs_t          bank_regs_r, bank_regs_nxt;
  logic [7:0]          bank_ctrl_r, bank_ctrl_nxt;
  logic                arrange_r, arrange_nxt;
  logic [7:0]          irq_lat_r, irq_lat_nxt;
  logic [7:0]          irq_count_r, irq_count_nxt;
  logic                irq_rld_r, irq_rld_nxt;
  logic                irq_en_r, irq_en_nxt;
  logic                irq_flag_r, irq_flag_nxt;

  logic                  out_adv;
  logic                  s1_fire;
  logic                  in_fire;
  reg_sel_t              sel;
  logic [2:0]            target;
  xlat_ctl_t             ctl;
  logic [ROM_ADDR_W-1:0] rom_addr;

  // The result register advances when empty or taken; the input register
  // refills whenever its item moves on.
  assign out_adv      = !out_valid_r || out_if.ready;
  assign s1_fire      = s1_valid_r && out_adv;
  assign in_if.ready  = !s1_valid_r || out_adv;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_valid_r;
  assign out_if.rom_addr    = out_rom_addr_r;
  assign out_if.irq_pend    = out_irq_r;
  assign out_if.mirror_code = out_mirror_r;

  // Translation reads the state as it stands before this item.
  assign ctl.bank_regs = bank_regs_r;
  assign ctl.bank_ctrl = bank_ctrl_r;
  assign ctl.prg_lg    = prg_lg_r;

  bsm_xlat #(
    .PRG_ADDR_WIDTH(PRG_ADDR_WIDTH)
  ) u_xlat (
    .mode    (s1_mode_r),
    .addr    (s1_addr_r),
    .ctl     (ctl),
    .rom_addr(rom_addr)
  );

  // Register writes and scanline clocks update the state in the same pass.
  always_comb begin
    sel           = reg_sel_t'(s1_addr_r[14:13]);
    target        = bank_ctrl_r[2:0];
    bank_regs_nxt = bank_regs_r;
    bank_ctrl_nxt = bank_ctrl_r;
    arrange_nxt   = arrange_r;
    irq_lat_nxt   = irq_lat_r;
    irq_count_nxt = irq_count_r;
    irq_rld_nxt   = irq_rld_r;
    irq_en_nxt    = irq_en_r;
    irq_flag_nxt  = irq_flag_r;

    unique case (s1_mode_r)
      MODE_WRITE: begin
        if (s1_addr_r[0]) begin
          unique case (sel)
            SEL_BANK: begin
              // R0 and R1 hold 2 KiB banks, R6 and R7 are program banks.
              if (target == BANK_R6 || target == BANK_R7) begin
                bank_regs_nxt[target] = s1_wdata_r & PRG_WIN_MASK;
              end else if (target == BANK_R0 || target == BANK_R1) begin
                bank_regs_nxt[target] = s1_wdata_r >> 1;
              end else begin
                bank_regs_nxt[target] = s1_wdata_r;
              end
            end
            SEL_MIRROR: begin
              // Program RAM protect is not modeled.
            end
            SEL_IRQ_LR: begin
              irq_count_nxt = 8'd0;
              irq_rld_nxt   = 1'b1;
            end
            default: begin
              irq_en_nxt = 1'b1;
            end
          endcase
        end else begin
          unique case (sel)
            SEL_BANK:   bank_ctrl_nxt = s1_wdata_r;
            SEL_MIRROR: arrange_nxt   = s1_wdata_r[0];
            SEL_IRQ_LR: irq_lat_nxt   = s1_wdata_r;
            default: begin
              irq_en_nxt   = 1'b0;
              irq_flag_nxt = 1'b0;
            end
          endcase
        end
      end
      MODE_CLOCK: begin
        if (irq_count_r == 8'd0 || irq_rld_r) begin
          irq_count_nxt = irq_lat_r;
        end else begin
          irq_count_nxt = irq_count_r - 8'd1;
        end
        if (irq_count_nxt == 8'd0 && irq_en_r) begin
          irq_flag_nxt = 1'b1;
        end
        irq_rld_nxt = 1'b0;
      end
      default: begin
        // Reads leave the state alone.
      end
    endcase
  end

  // Control state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prg_lg_r    <= PRG_LG_RESET;
      bank_regs_r <= '0;
      bank_ctrl_r <= 8'd0;
      arrange_r   <= 1'b0;
      irq_lat_r   <= 8'd0;
      irq_count_r <= 8'd0;
      irq_rld_r   <= 1'b0;
      irq_en_r    <= 1'b0;
      irq_flag_r  <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        prg_lg_r <= cfg_if.size_lg;
      end
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        bank_regs_r <= bank_regs_nxt;
        bank_ctrl_r <= bank_ctrl_nxt;
        arrange_r   <= arrange_nxt;
        irq_lat_r   <= irq_lat_nxt;
        irq_count_r <= irq_count_nxt;
        irq_rld_r   <= irq_rld_nxt;
        irq_en_r    <= irq_en_nxt;
        irq_flag_r  <= irq_flag_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r  <= mode_t'(in_if.mode);
      s1_addr_r  <= in_if.addr;
      s1_wdata_r <= in_if.wdata;
    end
    if (s1_fire) begin
      out_rom_addr_r <= rom_addr;
      out_irq_r      <= irq_flag_nxt;
      out_mirror_r   <= ~arrange_nxt;
    end
  end

  // The input register must not take an item while both registers are full
  // and the result is stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_if.ready |-> !in_if.ready)
    else $error("input accepted while both registers are full and stalled");

  // Writes and scanline clocks give a zero address.
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_mode_r == MODE_WRITE || s1_mode_r == MODE_CLOCK)
    |=> out_rom_addr_r == '0)
    else $error("non-read item gave a nonzero address");

  // A reload write clears the counter and arms the reload.
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_mode_r == MODE_WRITE && s1_addr_r[0] && s1_addr_r[14:13] == SEL_IRQ_LR
    |=> irq_count_r == 8'd0 && irq_rld_r)
    else $error("reload write did not clear the counter");

  // The pending flag only rises on a scanline clock.
  a_flag_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_flag_r) |-> $past(s1_fire && s1_mode_r == MODE_CLOCK))
    else $error("interrupt flag rose without a scanline clock");

  // Program bank registers never hold more than six bits.
  a_prg_bank_width: assert property (@(posedge clk) disable iff (!rst_n)
    bank_regs_r[BANK_R6][7:6] == 2'b00 && bank_regs_r[BANK_R7][7:6] == 2'b00)
    else $error("program bank register exceeds six bits");

endmodule
